### hw/rtl/stable_sort_engine_macros.svh
// Assertion macros used by the stable sort engine checker
`ifndef STABLE_SORT_ENGINE_MACROS_SVH
`define STABLE_SORT_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define SSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stable_sort_engine: check failed");

// Next-cycle implication, sampled on clk, held off during reset
`define SSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stable_sort_engine: check failed");

`endif

### hw/rtl/sse_pkg.sv
// Types shared by the stable sort engine modules
`timescale 1ns / 1ps

package sse_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     dropped;
    } out_item_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     push;
        logic signed [DATA_W-1:0] value;
    } cell_link_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                     insert;
        logic                     drain;
        logic signed [DATA_W-1:0] new_value;
    } cell_ctrl_t;

endpackage

### hw/rtl/sse_cell.sv
// One cell of the sorted chain: holds one value, shifts right on insert, left on drain
`timescale 1ns / 1ps

module sse_cell
    import sse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t left,
    input  cell_link_t right,
    output cell_link_t link
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     greater;
    logic                     push;

    // Strictly greater only, so a new value lands behind its equals
    assign greater = valid_reg && (value_reg > ctrl.new_value);
    // Empty cells count as greater; push is 0..0 1..1 along the chain
    assign push    = !valid_reg || greater;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.drain)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
        else if (ctrl.insert && push)
        begin
            if (left.push)
            begin
                valid_next = left.valid;
                value_next = left.value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = ctrl.new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.push  = push;
    assign link.value = value_reg;

endmodule

### hw/rtl/stable_sort_engine.sv
// Top level of the stable sort engine: batch control and the chain of sorting cells
`timescale 1ns / 1ps
// Stable ascending sort of a batch of signed 32-bit values.
// Input channel: item (value, last) is taken on a rising edge with start high
// and busy low. Each beat is inserted into a row of MAX_ITEMS cells in the
// same cycle, so loading runs at one value per cycle with no result.
// A beat with last set closes the batch. From the next cycle the chain
// drains: one result per cycle on result, marked by result_valid, the
// smallest first, equal values in arrival order. final_res marks the last
// result; dropped is set on every result of a batch that overflowed.
// The drain, one cell shift a cycle, sets the output rate.
// busy is high for the whole drain; start is ignored then.
// Beats past MAX_ITEMS are dropped (a last beat still closes the batch).
// Reset empties the chain and clears the count and drop flag.
// Results are not held: the receiver takes each in its one cycle.

module stable_sort_engine
    import sse_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      result_valid,
    output out_item_t result
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             drop_reg;
    logic             drop_next;
    logic             drain_reg;
    logic             drain_next;
    logic             accept;
    logic             full;
    cell_ctrl_t       ctrl;
    cell_link_t       chain [0:MAX_ITEMS+1];

    assign accept = start && !drain_reg;
    assign full   = (count_reg == CNT_W'(MAX_ITEMS));

    assign ctrl.insert    = accept && !full;
    assign ctrl.drain     = drain_reg;
    assign ctrl.new_value = item.value;

    // Boundary links: nothing pushes in from the left, empty on the right
    assign chain[0]           = '{valid: 1'b0, push: 1'b0, value: '0};
    assign chain[MAX_ITEMS+1] = '{valid: 1'b0, push: 1'b1, value: '0};

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        sse_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (chain[i]),
            .right (chain[i+2]),
            .link  (chain[i+1])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        drain_next = drain_reg;
        if (drain_reg)
        begin
            if (!chain[2].valid)
            begin
                drain_next = 1'b0;
                count_next = '0;
                drop_next  = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
            drain_next = item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            drain_reg <= drain_next;
        end
    end

    assign busy                = drain_reg;
    assign result_valid        = drain_reg;
    assign result.sorted_value = chain[1].value;
    assign result.final_res    = !chain[2].valid;
    assign result.dropped      = drop_reg;

endmodule

### hw/rtl/sse_checker.sv
// Port-level checker for the stable sort engine, bound to the top level
`timescale 1ns / 1ps
`include "stable_sort_engine_macros.svh"

module sse_checker
    import sse_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input in_item_t  item,
    input logic      result_valid,
    input out_item_t result
);

    `SSE_ASSERT_NOW(a_result_while_busy, result_valid, busy)
    `SSE_ASSERT_NEXT(a_drain_continues, result_valid && !result.final_res, result_valid)
    `SSE_ASSERT_NEXT(a_idle_after_final, result_valid && result.final_res, !busy)
    `SSE_ASSERT_NEXT(a_last_starts_drain, start && !busy && item.last, result_valid)
    `SSE_ASSERT_NEXT(a_drop_flag_steady, result_valid && !result.final_res, $stable(result.dropped))

endmodule

bind stable_sort_engine sse_checker u_sse_checker (.*);
